// ----- rtl/core/commissioning_stage_sequencer_macros.svh -----
// Assertion macros shared by the sequencer modules.
`ifndef COMMISSIONING_STAGE_SEQUENCER_MACROS_SVH
`define COMMISSIONING_STAGE_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define CSSEQ_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sequencer check failed");
`define CSSEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequencer check failed");
`else
`define CSSEQ_ASSERT(lbl, clk, rstn, ante, cons)
`define CSSEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/core/csseq_pkg.sv -----
`timescale 1ns / 1ps

package csseq_pkg;

    localparam int STAGE_COUNT = 8;
    localparam int STAGE_W     = 4;
    localparam int MASK_W      = 8;
    localparam int PROC_W      = 4;
    localparam int REASON_W    = 8;
    localparam int CMD_W       = 2;
    localparam int PCT_W       = 7;

    localparam logic [STAGE_W-1:0] STAGE_IDLE   = '0;
    localparam logic [STAGE_W-1:0] STAGE_LAST   = STAGE_W'(STAGE_COUNT);
    localparam logic [STAGE_W-1:0] STAGE_DONE   = STAGE_W'(STAGE_COUNT + 1);
    localparam logic [STAGE_W-1:0] STAGE_FAILED = STAGE_W'(STAGE_COUNT + 2);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // The dividend is done_count * 100, at most STAGE_COUNT * 100.
    localparam int DIVIDEND_W = $clog2(STAGE_COUNT * 100 + 1);
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CNT_W      = $clog2(MASK_W + 1);

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_START    = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_FAIL     = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic update;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

    function automatic logic [PROC_W-1:0] proc_of_stage(input logic [STAGE_W-1:0] st);
        logic [PROC_W-1:0] p;
        case (st)
            4'd1:    p = 4'd1;
            4'd2:    p = 4'd2;
            4'd3:    p = 4'd3;
            4'd4:    p = 4'd5;
            4'd5:    p = 4'd6;
            4'd6:    p = 4'd8;
            4'd7:    p = 4'd9;
            4'd8:    p = 4'd10;
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    // First enabled stage after the given one, or the done code.
    function automatic logic [STAGE_W-1:0] next_enabled(input logic [STAGE_W-1:0] after,
                                                        input logic [MASK_W-1:0] mask);
        logic [STAGE_W-1:0] r;
        r = STAGE_DONE;
        for (int i = STAGE_COUNT; i >= 1; i--) begin
            if ((i > int'(after)) && mask[i-1]) begin
                r = STAGE_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] popcount(input logic [MASK_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < MASK_W; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic service_ok(input logic [PROC_W-1:0] proc,
                                        input logic [MASK_W-1:0] mask);
        logic ok;
        case (proc)
            4'd1:                 ok = mask[0];
            4'd2:                 ok = mask[1];
            4'd3:                 ok = mask[2];
            4'd4, 4'd5:           ok = mask[3];
            4'd6, 4'd7:           ok = mask[4];
            4'd8:                 ok = mask[5];
            4'd9:                 ok = mask[6];
            4'd10, 4'd11, 4'd12:  ok = 1'b1;
            default:              ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ----- rtl/core/csseq_dp.sv -----
`timescale 1ns / 1ps
`include "commissioning_stage_sequencer_macros.svh"

module csseq_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  csseq_pkg::dp_cmd_t                    cmd,
    output csseq_pkg::dp_status_t                 status,
    input  logic [csseq_pkg::CMD_W-1:0]           in_command,
    input  logic [csseq_pkg::PROC_W-1:0]          in_procedure,
    input  logic [csseq_pkg::REASON_W-1:0]        in_reason,
    input  logic                                  cfg_wr_en,
    input  logic [csseq_pkg::MASK_W-1:0]          cfg_wr_data,
    output logic [csseq_pkg::OUT_DATA_W-1:0]      out_data
);

    csseq_pkg::cmd_t                       cmd_reg;
    logic [csseq_pkg::PROC_W-1:0]          proc_reg;
    logic [csseq_pkg::REASON_W-1:0]        reason_reg;

    logic [csseq_pkg::MASK_W-1:0]          en_reg, en_next;
    logic [csseq_pkg::STAGE_W-1:0]         stage_reg, stage_next;
    logic                                  running_reg, running_next;
    logic [csseq_pkg::MASK_W-1:0]          done_reg, done_next;
    logic [csseq_pkg::STAGE_W-1:0]         fstage_reg, fstage_next;
    logic [csseq_pkg::REASON_W-1:0]        fcode_reg, fcode_next;
    logic                                  acc_reg, acc_next;
    logic                                  fin_reg, fin_next;

    logic [csseq_pkg::CNT_W-1:0]           rem_reg, rem_next;
    logic [csseq_pkg::DIVIDEND_W-1:0]      quo_reg, quo_next;
    logic [csseq_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [csseq_pkg::OUT_DATA_W-1:0]      data_reg, data_next;

    logic [csseq_pkg::STAGE_W-1:0]         stage_nx;
    logic [csseq_pkg::CNT_W-1:0]           en_cnt;
    logic [csseq_pkg::CNT_W-1:0]           dn_cnt;
    logic [csseq_pkg::CNT_W:0]             trial;
    logic [csseq_pkg::PCT_W-1:0]           pct;
    logic [csseq_pkg::PROC_W-1:0]          next_proc;

    assign en_cnt = csseq_pkg::popcount(en_reg);
    assign status.div_last = (cnt_reg == csseq_pkg::DIV_CNT_W'(csseq_pkg::DIV_STEPS - 1));
    assign out_data = data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg    <= csseq_pkg::cmd_t'(in_command);
            proc_reg   <= in_procedure;
            reason_reg <= in_reason;
        end
    end

    always_comb begin
        en_next      = en_reg;
        stage_next   = stage_reg;
        running_next = running_reg;
        done_next    = done_reg;
        fstage_next  = fstage_reg;
        fcode_next   = fcode_reg;
        acc_next     = acc_reg;
        fin_next     = fin_reg;
        stage_nx     = csseq_pkg::next_enabled(stage_reg, en_reg);

        // Register writes during a run are dropped.
        if (cfg_wr_en && !running_reg) begin
            en_next = cfg_wr_data;
        end

        if (cmd.update) begin
            acc_next = 1'b0;
            fin_next = 1'b0;
            case (cmd_reg)
                csseq_pkg::CMD_START: begin
                    if (!running_reg) begin
                        stage_next  = csseq_pkg::STAGE_IDLE;
                        fstage_next = csseq_pkg::STAGE_IDLE;
                        done_next   = '0;
                        fcode_next  = '0;
                        if (en_reg != '0) begin
                            running_next = 1'b1;
                            stage_next   = csseq_pkg::next_enabled(csseq_pkg::STAGE_IDLE,
                                                                   en_reg);
                            acc_next     = 1'b1;
                        end
                    end
                end
                csseq_pkg::CMD_COMPLETE: begin
                    if (running_reg && (proc_reg == csseq_pkg::proc_of_stage(stage_reg))) begin
                        done_next  = done_reg
                                   | (csseq_pkg::MASK_W'(1) << (stage_reg - 4'd1));
                        stage_next = stage_nx;
                        acc_next   = 1'b1;
                        if (stage_nx == csseq_pkg::STAGE_DONE) begin
                            running_next = 1'b0;
                            fin_next     = 1'b1;
                        end
                    end
                end
                csseq_pkg::CMD_FAIL: begin
                    if (running_reg) begin
                        fstage_next  = stage_reg;
                        fcode_next   = reason_reg;
                        stage_next   = csseq_pkg::STAGE_FAILED;
                        running_next = 1'b0;
                        acc_next     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Restoring division of done_count * 100 by the enabled count, one bit a cycle.
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        dn_cnt   = csseq_pkg::popcount(done_next & en_reg);
        trial    = {rem_reg, quo_reg[csseq_pkg::DIVIDEND_W-1]};
        if (cmd.update) begin
            rem_next = '0;
            quo_next = csseq_pkg::DIVIDEND_W'(dn_cnt)
                     * csseq_pkg::DIVIDEND_W'(csseq_pkg::PCT_FULL);
            cnt_next = '0;
        end else if (cmd.div_step) begin
            if (trial >= {1'b0, en_cnt}) begin
                rem_next = csseq_pkg::CNT_W'(trial - {1'b0, en_cnt});
                quo_next = {quo_reg[csseq_pkg::DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[csseq_pkg::CNT_W-1:0];
                quo_next = {quo_reg[csseq_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        if (stage_reg == csseq_pkg::STAGE_DONE) begin
            pct = csseq_pkg::PCT_FULL;
        end else if ((stage_reg == csseq_pkg::STAGE_IDLE) || (en_cnt == '0)) begin
            pct = '0;
        end else begin
            pct = quo_reg[csseq_pkg::PCT_W-1:0];
        end
        next_proc = running_reg ? csseq_pkg::proc_of_stage(stage_reg) : '0;
        data_next = data_reg;
        if (cmd.load_out) begin
            data_next = {1'b0, fcode_reg, fstage_reg, pct, running_reg, stage_reg,
                         csseq_pkg::service_ok(proc_reg, en_reg), fin_reg, next_proc,
                         acc_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg      <= '1;
            stage_reg   <= csseq_pkg::STAGE_IDLE;
            running_reg <= 1'b0;
            done_reg    <= '0;
            fstage_reg  <= csseq_pkg::STAGE_IDLE;
            fcode_reg   <= '0;
            acc_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            en_reg      <= en_next;
            stage_reg   <= stage_next;
            running_reg <= running_next;
            done_reg    <= done_next;
            fstage_reg  <= fstage_next;
            fcode_reg   <= fcode_next;
            acc_reg     <= acc_next;
            fin_reg     <= fin_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        data_reg <= data_next;
    end

    `CSSEQ_ASSERT(a_running_stage, aclk, aresetn, running_reg, (stage_reg != csseq_pkg::STAGE_IDLE) && (stage_reg <= csseq_pkg::STAGE_LAST))
    `CSSEQ_ASSERT(a_pct_range, aclk, aresetn, cmd.load_out, pct <= csseq_pkg::PCT_FULL)

endmodule

// ----- rtl/core/csseq_ctrl.sv -----
`timescale 1ns / 1ps
`include "commissioning_stage_sequencer_macros.svh"

module csseq_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output csseq_pkg::dp_cmd_t     dp_cmd,
    input  csseq_pkg::dp_status_t  dp_status
);

    csseq_pkg::state_t state_reg, state_next;
    logic              m_tvalid_reg, m_tvalid_next;

    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= csseq_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        s_tready   = 1'b0;
        case (state_reg)
            csseq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = csseq_pkg::ST_UPDATE;
                end
            end
            csseq_pkg::ST_UPDATE: begin
                dp_cmd.update = 1'b1;
                state_next    = csseq_pkg::ST_DIV;
            end
            csseq_pkg::ST_DIV: begin
                dp_cmd.div_step = 1'b1;
                if (dp_status.div_last) begin
                    state_next = csseq_pkg::ST_OUT;
                end
            end
            csseq_pkg::ST_OUT: begin
                // The previous result may still be waiting in the output register.
                if (!m_tvalid_reg || m_tready) begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = csseq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csseq_pkg::ST_IDLE;
            end
        endcase

        if (dp_cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    `CSSEQ_ASSERT_NEXT(a_accept_update, aclk, aresetn, s_tvalid && s_tready, state_reg == csseq_pkg::ST_UPDATE)
    `CSSEQ_ASSERT_NEXT(a_stall_holds, aclk, aresetn, (state_reg == csseq_pkg::ST_OUT) && m_tvalid_reg && !m_tready, state_reg == csseq_pkg::ST_OUT)
    `CSSEQ_ASSERT(a_valid_source, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == csseq_pkg::ST_OUT))

endmodule

// ----- rtl/core/commissioning_stage_sequencer.sv -----
`timescale 1ns / 1ps
// Commissioning stage sequencer.
// Input channel (s_axis_*): one beat is one command. tuser carries the command
// code (start, complete, fail, query); tdata carries the procedure code and
// the failure reason. Output channel (m_axis_*): exactly one result beat per
// command, with the acceptance flag, expected next procedure, done flag,
// service permission, stage, running flag, progress percent and failure record.
// The stage enable mask is written through cfg_wr_en / cfg_wr_data; writes
// while a workflow is running are ignored.
// Each command passes the states ST_UPDATE (update the stage state), ST_DIV (a
// one-bit-per-cycle restoring divider for the progress percent) and ST_OUT
// (load the output register); the next command is taken only once the previous
// one has left ST_OUT.
// A new command is taken while the previous result waits on the output; if the
// receiver stalls, the next result waits in the sequencer until the output
// register frees. Reset (aresetn low, synchronous) enables all stages, clears
// the history to idle and drops m_axis_tvalid.

module commissioning_stage_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [csseq_pkg::MASK_W-1:0]         cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [3:0] procedure, [11:4] fail_reason, [15:12] zero
    input  logic [csseq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] command
    input  logic [csseq_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] accepted, [4:1] expected_proc, [5] workflow_done, [6] service_allowed,
    // [10:7] current_stage, [11] running, [18:12] progress_percent,
    // [22:19] failed_at_stage, [30:23] stored_reason, [31] zero
    output logic [csseq_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    csseq_pkg::dp_cmd_t    dp_cmd;
    csseq_pkg::dp_status_t dp_status;

    csseq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    csseq_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .in_command   (s_axis_tuser),
        .in_procedure (s_axis_tdata[csseq_pkg::PROC_W-1:0]),
        .in_reason    (s_axis_tdata[csseq_pkg::PROC_W +: csseq_pkg::REASON_W]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_data     (m_axis_tdata)
    );

endmodule

// ----- tb/commissioning_checker.sv -----
`timescale 1ns / 1ps

module commissioning_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [csseq_pkg::MASK_W-1:0]         cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic [csseq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [csseq_pkg::CMD_W-1:0]          s_axis_tuser,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [csseq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output int                                   mismatch_count,
    output int                                   results_owed
);
    import csseq_pkg::*;

    // Procedure expected by each stage, four bits per stage, stage 0 lowest.
    localparam logic [35:0] STAGE_PROCS =
        {4'd10, 4'd9, 4'd8, 4'd6, 4'd5, 4'd3, 4'd2, 4'd1, 4'd0};

    typedef struct packed {
        logic                 accepted;
        logic [PROC_W-1:0]    next_proc;
        logic                 done;
        logic                 service;
        logic [STAGE_W-1:0]   stage;
        logic                 running;
        logic [PCT_W-1:0]     percent;
        logic [STAGE_W-1:0]   fail_stage;
        logic [REASON_W-1:0]  fail_code;
    } status_t;

    logic [MASK_W-1:0]   stage_mask;
    logic [STAGE_W-1:0]  stage_now;
    logic                active;
    logic [MASK_W-1:0]   finished;
    logic [STAGE_W-1:0]  fail_stage;
    logic [REASON_W-1:0] fail_code;
    status_t             owed[$];
    int                  fail_total = 0;

    function automatic logic [PROC_W-1:0] stage_procedure(input logic [STAGE_W-1:0] st);
        logic [PROC_W-1:0] p;
        p = '0;
        if (st >= 4'd1 && st <= STAGE_LAST) begin
            p = STAGE_PROCS[int'(st) * 4 +: 4];
        end
        return p;
    endfunction

    function automatic logic [STAGE_W-1:0] enabled_after(input logic [STAGE_W-1:0] after,
                                                         input logic [MASK_W-1:0] mask);
        logic [STAGE_W-1:0] found;
        found = STAGE_DONE;
        for (int s = STAGE_COUNT; s > int'(after); s--) begin
            if (mask[s-1]) begin
                found = STAGE_W'(s);
            end
        end
        return found;
    endfunction

    function automatic int ones(input logic [MASK_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < MASK_W; i++) begin
            n += int'(v[i]);
        end
        return n;
    endfunction

    // Procedures 4..9 map onto the stage that covers them; 10..12 are always allowed.
    function automatic logic service_permitted(input logic [PROC_W-1:0] proc,
                                               input logic [MASK_W-1:0] mask);
        logic ok;
        case (proc)
            4'd1, 4'd2, 4'd3:    ok = mask[proc - 4'd1];
            4'd4, 4'd5:          ok = mask[3];
            4'd6, 4'd7:          ok = mask[4];
            4'd8, 4'd9:          ok = mask[proc - 4'd3];
            4'd10, 4'd11, 4'd12: ok = 1'b1;
            default:             ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [PCT_W-1:0] percent_done();
        int en;
        logic [PCT_W-1:0] pct;
        en = ones(stage_mask);
        if (stage_now == STAGE_DONE) begin
            pct = PCT_FULL;
        end else if (stage_now == STAGE_IDLE || en == 0) begin
            pct = '0;
        end else begin
            pct = PCT_W'(ones(finished & stage_mask) * 100 / en);
        end
        return pct;
    endfunction

    task automatic predict_command(input cmd_t cmd, input logic [PROC_W-1:0] proc,
                                   input logic [REASON_W-1:0] why);
        status_t r;
        r = '0;
        case (cmd)
            CMD_START: begin
                if (!active) begin
                    stage_now = STAGE_IDLE;
                    fail_stage = STAGE_IDLE;
                    finished = '0;
                    fail_code = '0;
                    if (stage_mask != '0) begin
                        active = 1'b1;
                        stage_now = enabled_after(STAGE_IDLE, stage_mask);
                        r.accepted = stage_procedure(stage_now) != '0;
                    end
                end
            end
            CMD_COMPLETE: begin
                if (active && proc == stage_procedure(stage_now)) begin
                    if (stage_now >= 4'd1 && stage_now <= STAGE_LAST) begin
                        finished[stage_now - 4'd1] = 1'b1;
                    end
                    stage_now = enabled_after(stage_now, stage_mask);
                    if (stage_now == STAGE_DONE) begin
                        active = 1'b0;
                        r.done = 1'b1;
                        r.accepted = 1'b1;
                    end else begin
                        r.accepted = stage_procedure(stage_now) != '0;
                    end
                end
            end
            CMD_FAIL: begin
                if (active) begin
                    fail_stage = stage_now;
                    fail_code = why;
                    stage_now = STAGE_FAILED;
                    active = 1'b0;
                    r.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.next_proc = active ? stage_procedure(stage_now) : '0;
        r.service = service_permitted(proc, stage_mask);
        r.stage = stage_now;
        r.running = active;
        r.percent = percent_done();
        r.fail_stage = fail_stage;
        r.fail_code = fail_code;
        owed.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] d);
        status_t w;
        if (owed.size() == 0) begin
            $error("result beat with no command outstanding: %h", d);
            fail_total++;
        end else begin
            w = owed.pop_front();
            check_field("accepted", w.accepted, d[0]);
            check_field("expected_proc", w.next_proc, d[4:1]);
            check_field("workflow_done", w.done, d[5]);
            check_field("service_allowed", w.service, d[6]);
            check_field("current_stage", w.stage, d[10:7]);
            check_field("running", w.running, d[11]);
            check_field("progress_percent", w.percent, d[18:12]);
            check_field("failed_at_stage", w.fail_stage, d[22:19]);
            check_field("stored_reason", w.fail_code, d[30:23]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            stage_mask = '1;
            stage_now = STAGE_IDLE;
            active = 1'b0;
            finished = '0;
            fail_stage = STAGE_IDLE;
            fail_code = '0;
            owed.delete();
        end else begin
            // The mask only takes a write while no workflow is running.
            if (cfg_wr_en && !active) begin
                stage_mask = cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_command(cmd_t'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[11:4]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
            end
        end
        mismatch_count <= fail_total;
        results_owed <= owed.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import csseq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int STEP_TARGET = 1350;
    localparam int CALM_TAIL   = 150;
    localparam logic [35:0] STAGE_PROCS =
        {4'd10, 4'd9, 4'd8, 4'd6, 4'd5, 4'd3, 4'd2, 4'd1, 4'd0};

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [MASK_W-1:0]       cfg_wr_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    wire                     s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [CMD_W-1:0]        s_axis_tuser = '0;
    wire                     m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    wire  [OUT_DATA_W-1:0]   m_axis_tdata;
    int                      mismatch_count;
    int                      results_owed;

    // Stimulus-side view of the workflow, used to build well-formed sequences.
    logic                    calm = 1'b0;
    logic                    wf_running = 1'b0;
    logic [MASK_W-1:0]       live_mask = '1;
    logic [PROC_W-1:0]       want_proc = '0;
    int                      steps_sent = 0;

    commissioning_stage_sequencer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    commissioning_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stall bursts until the calm tail of the run.
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 11) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [PROC_W-1:0] stage_proc(input int st);
        return STAGE_PROCS[st * 4 +: 4];
    endfunction

    task automatic send_command(input cmd_t cmd, input logic [PROC_W-1:0] proc,
                                input logic [REASON_W-1:0] why);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'b0000, why, proc};
        do @(posedge aclk); while (!s_axis_tready);
        steps_sent++;
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every outstanding result has been taken.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (!wf_running) begin
            live_mask = m;
        end
    endtask

    // A beat that leaves the workflow untouched: query, wrong completion,
    // start while running or fail while stopped.
    task automatic send_noise();
        logic [PROC_W-1:0] p;
        int pick;
        p = PROC_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            send_command(CMD_QUERY, p, REASON_W'($urandom_range(0, 255)));
        end else if (pick == 1) begin
            if (wf_running && p == want_proc) begin
                p = p + 4'd1;
            end
            send_command(CMD_COMPLETE, p, REASON_W'($urandom_range(0, 255)));
        end else if (wf_running) begin
            send_command(CMD_START, p, REASON_W'($urandom_range(0, 255)));
        end else begin
            send_command(CMD_FAIL, p, REASON_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_workflow();
        logic [MASK_W-1:0] m;
        int pick;
        bit quit;
        pick = $urandom_range(0, 15);
        case (pick)
            0:       m = 8'h00;
            1:       m = 8'hFF;
            2:       m = MASK_W'(1) << $urandom_range(0, 7);
            3:       m = 8'h80;
            default: m = MASK_W'($urandom_range(1, 255));
        endcase
        settle();
        write_mask(m);
        // A workflow left running from the last phase kept the old mask; end it.
        if (wf_running) begin
            send_command(CMD_FAIL, PROC_W'($urandom_range(0, 15)),
                         REASON_W'($urandom_range(0, 255)));
            wf_running = 1'b0;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_noise();
        end
        send_command(CMD_START, PROC_W'($urandom_range(0, 15)),
                     REASON_W'($urandom_range(0, 255)));
        if (live_mask != '0) begin
            wf_running = 1'b1;
            quit = 1'b0;
            for (int st = 1; st <= STAGE_COUNT && !quit; st++) begin
                if (live_mask[st-1]) begin
                    want_proc = stage_proc(st);
                    while ($urandom_range(0, 4) == 0) begin
                        send_noise();
                    end
                    pick = $urandom_range(0, 29);
                    if (pick == 0) begin
                        send_command(CMD_FAIL, PROC_W'($urandom_range(0, 15)),
                                     REASON_W'($urandom_range(0, 255)));
                        wf_running = 1'b0;
                        quit = 1'b1;
                    end else if (pick == 1) begin
                        quit = 1'b1;
                    end else begin
                        send_command(CMD_COMPLETE, want_proc,
                                     REASON_W'($urandom_range(0, 255)));
                    end
                end
            end
            if (!quit) begin
                wf_running = 1'b0;
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            send_noise();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Service permission edges and commands that find no workflow running.
        send_command(CMD_QUERY, 4'd0, 8'h00);
        send_command(CMD_QUERY, 4'd15, 8'hFF);
        send_command(CMD_QUERY, 4'd12, 8'h5A);
        send_command(CMD_QUERY, 4'd4, 8'hA5);
        send_command(CMD_COMPLETE, 4'd1, 8'h00);
        send_command(CMD_FAIL, 4'd0, 8'h33);

        // Full pass with all stages enabled, plus a refused restart and a wrong completion.
        send_command(CMD_START, 4'd0, 8'h00);
        send_command(CMD_START, 4'd0, 8'h00);
        send_command(CMD_COMPLETE, 4'd2, 8'h00);
        for (int st = 1; st <= STAGE_COUNT; st++) begin
            send_command(CMD_COMPLETE, stage_proc(st), 8'h00);
        end

        // Start with nothing enabled still clears the history.
        settle();
        write_mask(8'h00);
        send_command(CMD_START, 4'd0, 8'h00);

        // Fail on the last stage, then look at progress with no stage enabled.
        settle();
        write_mask(8'h80);
        send_command(CMD_START, 4'd0, 8'h00);
        send_command(CMD_FAIL, 4'd10, 8'hFF);
        settle();
        write_mask(8'h00);
        send_command(CMD_QUERY, 4'd1, 8'h00);
        send_command(CMD_START, 4'd0, 8'h00);

        // A mask write during a running workflow must be ignored.
        settle();
        write_mask(8'hFF);
        send_command(CMD_START, 4'd0, 8'h00);
        settle();
        wf_running = 1'b1;
        write_mask(8'h01);
        send_command(CMD_COMPLETE, 4'd1, 8'h00);
        send_command(CMD_FAIL, 4'd2, 8'h00);
        wf_running = 1'b0;
        live_mask = 8'hFF;

        while (steps_sent < STEP_TARGET) begin
            calm = steps_sent >= STEP_TARGET - CALM_TAIL;
            run_workflow();
        end

        settle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/csseq_pkg.sv
rtl/core/csseq_dp.sv
rtl/core/csseq_ctrl.sv
rtl/core/commissioning_stage_sequencer.sv
tb/commissioning_checker.sv
tb/testbench.sv
